### sv/nibble_precision_register_alu_unit_defines.svh
// ---------------------------------------------------------------------------
// Nibble precision register ALU - assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef NIBBLE_PRECISION_REGISTER_ALU_UNIT_DEFINES_SVH
`define NIBBLE_PRECISION_REGISTER_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define NPRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/npra_pkg.sv
// ---------------------------------------------------------------------------
// npra_pkg
// Shared constants, codes and types of the nibble precision register ALU.
// ---------------------------------------------------------------------------
package npra_pkg;

  localparam int NUM_REGS = 16;
  localparam int NIBBLES  = 4;
  localparam int REG_W    = 4 * NIBBLES;
  localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int BITS_W   = $clog2(REG_W + 1);

  localparam logic [2:0] CMD_RSUB = 3'd0;
  localparam logic [2:0] CMD_INC  = 3'd1;
  localparam logic [2:0] CMD_DEC  = 3'd2;
  localparam logic [2:0] CMD_SHL  = 3'd3;
  localparam logic [2:0] CMD_SHR  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [IDX_W-1:0] idx_x;
    logic [15:0]      amount;
    logic [1:0]       precision;
    logic             bad;
  } op_t;

  typedef struct packed {
    logic [REG_W-1:0] value;
    logic             zero;
  } alu_res_t;

  // Field width in bits for a precision code, limited to the register.
  function automatic logic [BITS_W-1:0] field_bits(input logic [1:0] prec);
    int nib;
    nib = int'(prec) + 1;
    if (nib > NIBBLES) nib = NIBBLES;
    return BITS_W'(4 * nib);
  endfunction

endpackage

### sv/npra_ch_if.sv
// ---------------------------------------------------------------------------
// npra_in_if / npra_out_if
// Valid/ready channels for instructions and results.
// ---------------------------------------------------------------------------
interface npra_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [4:0]  reg_x;
  logic [4:0]  reg_y;
  logic [15:0] amount;
  logic [1:0]  precision;

  modport source (output valid, cmd, reg_x, reg_y, amount, precision, input ready);
  modport sink   (input valid, cmd, reg_x, reg_y, amount, precision, output ready);
endinterface

interface npra_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        zero;
  logic [15:0] value;
  logic [1:0]  delay;

  modport source (output valid, status, zero, value, delay, input ready);
  modport sink   (input valid, status, zero, value, delay, output ready);
endinterface

### sv/npra_rf.sv
// ---------------------------------------------------------------------------
// npra_rf
// Register file: one write port, two registered read ports, per-entry
// valid bits so that unwritten entries read as zero straight after reset.
// ---------------------------------------------------------------------------
module npra_rf
  import npra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr_x,
  input  logic [IDX_W-1:0] rd_addr_y,
  output logic [REG_W-1:0] rd_data_x,
  output logic [REG_W-1:0] rd_data_y,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [REG_W-1:0] wr_data
);

  logic [REG_W-1:0]    mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [REG_W-1:0]    dx_r;
  logic [REG_W-1:0]    dy_r;
  logic                vx_r;
  logic                vy_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dx_r <= mem[rd_addr_x];
      dy_r <= mem[rd_addr_y];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vx_r  <= 1'b0;
      vy_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vx_r <= vld_r[rd_addr_x];
        vy_r <= vld_r[rd_addr_y];
      end
    end
  end

  assign rd_data_x = vx_r ? dx_r : '0;
  assign rd_data_y = vy_r ? dy_r : '0;

endmodule

### sv/npra_alu.sv
// ---------------------------------------------------------------------------
// npra_alu
// Field arithmetic: reverse subtract, add, subtract and logical shifts on
// the low precision+1 nibbles, upper nibbles merged back unchanged.
// ---------------------------------------------------------------------------
module npra_alu
  import npra_pkg::*;
(
  input  op_t              op,
  input  logic [REG_W-1:0] cur_x,
  input  logic [REG_W-1:0] cur_y,
  output alu_res_t         res
);

  logic [BITS_W-1:0] bits;
  logic [REG_W-1:0]  fmask;
  logic [REG_W-1:0]  fx;
  logic [REG_W-1:0]  fy;
  logic [REG_W-1:0]  amt;
  logic              big_shift;
  logic [REG_W-1:0]  raw;
  logic [REG_W-1:0]  fres;

  always_comb begin
    bits      = field_bits(op.precision);
    fmask     = ~({REG_W{1'b1}} << bits);
    fx        = cur_x & fmask;
    fy        = cur_y & fmask;
    amt       = REG_W'(op.amount);
    big_shift = (op.amount >= 16'(bits));
    case (op.cmd)
      CMD_RSUB: raw = fy - fx;
      CMD_INC:  raw = fx + amt;
      CMD_DEC:  raw = fx - amt;
      CMD_SHL:  raw = big_shift ? '0 : (fx << op.amount);
      default:  raw = big_shift ? '0 : (fx >> op.amount);
    endcase
    fres      = raw & fmask;
    res.value = (cur_x & ~fmask) | fres;
    res.zero  = (fres == '0);
  end

endmodule

### sv/nibble_precision_register_alu_unit.sv
// ---------------------------------------------------------------------------
// nibble_precision_register_alu_unit
// Runs one register instruction per transaction on a file of sixteen
// 16-bit registers held in a synchronous memory.
//
//   channel  role    payload
//   in_ch    sink    cmd, reg_x, reg_y, amount, precision
//   out_ch   source  status, zero, value, delay
//
// Each transaction: register file read, then execute and write back.
// The registered memory read port sets the read step; execute stalls while
// the output register still holds an untaken result, and a new transaction
// is taken while that result waits. Reset is synchronous; the register file
// reads as zero at once through per-entry valid bits, with no clearing pass.
// ---------------------------------------------------------------------------
module nibble_precision_register_alu_unit
  import npra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  npra_in_if.sink           in_ch,
  npra_out_if.source        out_ch
);

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic             zflag_r, zflag_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r;
  logic             out_zero_r;
  logic [15:0]      out_value_r;
  logic [1:0]       out_delay_r;

  logic             accept;
  logic             done;
  logic             rf_we;
  logic             in_ready;
  logic             x_ok;
  logic             y_ok;
  logic [REG_W-1:0] rd_x;
  logic [REG_W-1:0] rd_y;
  logic [IDX_W-1:0] idx_y;
  alu_res_t         alu_res;

  assign x_ok   = (in_ch.reg_x != 5'd0) && (int'(in_ch.reg_x) <= NUM_REGS);
  assign y_ok   = (in_ch.reg_y != 5'd0) && (int'(in_ch.reg_y) <= NUM_REGS);
  assign idx_y  = IDX_W'(in_ch.reg_y - 5'd1);
  assign accept = in_ch.valid && in_ready;

  always_comb begin
    op_nxt           = op_r;
    if (accept) begin
      op_nxt.cmd       = in_ch.cmd;
      op_nxt.idx_x     = IDX_W'(in_ch.reg_x - 5'd1);
      op_nxt.amount    = in_ch.amount;
      op_nxt.precision = in_ch.precision;
      op_nxt.bad       = (in_ch.cmd > CMD_SHR) || !x_ok ||
                         ((in_ch.cmd == CMD_RSUB) && !y_ok);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: done     = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign rf_we = done && !op_r.bad;

  npra_rf u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_x (op_nxt.idx_x),
    .rd_addr_y (idx_y),
    .rd_data_x (rd_x),
    .rd_data_y (rd_y),
    .wr_en     (rf_we),
    .wr_addr   (op_r.idx_x),
    .wr_data   (alu_res.value)
  );

  npra_alu u_alu (
    .op    (op_r),
    .cur_x (rd_x),
    .cur_y (rd_y),
    .res   (alu_res)
  );

  assign zflag_nxt     = rf_we ? alu_res.zero : zflag_r;
  assign out_valid_nxt = done ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      zflag_r     <= zflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (done) begin
      out_status_r <= op_r.bad ? STATUS_BAD : STATUS_OK;
      out_zero_r   <= zflag_nxt;
      out_value_r  <= op_r.bad ? 16'd0 : 16'(alu_res.value);
      out_delay_r  <= op_r.bad ? 2'd0 : op_r.precision;
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.zero   = out_zero_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.delay  = out_delay_r;

`include "nibble_precision_register_alu_unit_defines.svh"

  `NPRA_ASSERT_NEXT(a_accept_to_exec, accept, state_r == ST_EXEC, "accept did not start execute")
  `NPRA_ASSERT_NEXT(a_done_fills_out, done, out_valid_r, "finished transaction left no result")
  `NPRA_ASSERT_NOW(a_write_only_exec, rf_we, (state_r == ST_EXEC) && !op_r.bad, "stray write")
  `NPRA_ASSERT_NEXT(a_bad_result, done && op_r.bad, (out_status_r == STATUS_BAD) && (out_value_r == 16'd0) && (out_zero_r == zflag_r), "rejected result wrong")

endmodule
